/* rtl/dmn_pkg.sv */
// Shared types and constants for the distributed mutex node.
package dmn_pkg;

  localparam int unsigned MAX_NODES_DEF   = 16;
  localparam int unsigned NODE_CNT_W      = 5;
  localparam int unsigned NODE_IDX_W      = 4;
  localparam int unsigned SEQ_W           = 32;
  localparam int unsigned CFG_DATA_W      = 5;
  localparam logic [NODE_CNT_W-1:0] NODE_COUNT_RST = 5'd16;

  typedef enum logic [2:0] {
    CMD_CLIENT_REQ   = 3'd0,
    CMD_CLIENT_REL   = 3'd1,
    CMD_CLIENT_DONE  = 3'd2,
    CMD_PEER_REQ     = 3'd3,
    CMD_PEER_REPLY   = 3'd4,
    CMD_PEER_SHUT    = 3'd5,
    CMD_SHUT_ACK     = 3'd6,
    CMD_UNUSED       = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_GRANT       = 3'd0,
    KIND_REQ_PEER    = 3'd1,
    KIND_REPLY_PEER  = 3'd2,
    KIND_SHUT_NOTICE = 3'd3,
    KIND_SHUT_ACK    = 3'd4,
    KIND_EXIT        = 3'd5
  } kind_t;

  typedef enum logic {
    CFG_NODE_COUNT = 1'b0,
    CFG_OWN_INDEX  = 1'b1
  } cfg_idx_t;

endpackage

/* rtl/distributed_mutex_node.sv */
// Ricart-Agrawala mutual exclusion node with shutdown handshake (top level).
//
//  channel   direction  handshake          payload
//  in_*      input      in_valid/in_ready   cmd, source_index, seq_number
//  out_*     output     out_valid/out_ready kind, dest_index, seq_out, last
//  cfg_*     input      cfg_we              cfg_index, cfg_wdata
//
// An item is taken in IDLE and decoded in EXEC; broadcasts and releases then
// scan the node indices below the node count in SCAN, and the final result is
// handed over in FLUSH.
// in_ready is high only while the sequencer is idle.
// A stalled output holds the scan in place; one result is kept pending so
// the final one can be flagged last. Reset is synchronous, active low.
module distributed_mutex_node #(
  parameter int unsigned MAX_NODES = dmn_pkg::MAX_NODES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         in_cmd,
  input  logic [dmn_pkg::NODE_IDX_W-1:0]     in_source_index,
  input  logic [dmn_pkg::SEQ_W-1:0]          in_seq_number,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         out_kind,
  output logic [dmn_pkg::NODE_IDX_W-1:0]     out_dest_index,
  output logic [dmn_pkg::SEQ_W-1:0]          out_seq_out,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [dmn_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
  localparam int unsigned IDX_W = $clog2(MAX_NODES);
  localparam int unsigned NW    = (CNT_W > dmn_pkg::NODE_CNT_W) ? CNT_W : dmn_pkg::NODE_CNT_W;
  localparam int unsigned IW    = dmn_pkg::NODE_IDX_W;
  localparam int unsigned SW    = dmn_pkg::SEQ_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [dmn_pkg::NODE_CNT_W-1:0] v);
    logic [NW-1:0] ext;
    logic [NW-1:0] res;
    ext = NW'(v);
    if (ext == '0)
      res = NW'(1);
    else if (ext > NW'(MAX_NODES))
      res = NW'(MAX_NODES);
    else
      res = ext;
    return CNT_W'(res);
  endfunction

  function automatic logic [CNT_W-1:0] minus_one_floor(input logic [CNT_W-1:0] v);
    return (v > CNT_W'(1)) ? v - CNT_W'(1) : '0;
  endfunction

  // control state
  state_t                         state_r, state_nxt;
  logic [dmn_pkg::NODE_CNT_W-1:0] node_count_r, node_count_nxt;
  logic [IW-1:0]                  own_index_r, own_index_nxt;
  logic [SW-1:0]                  own_seq_r, own_seq_nxt;
  logic [SW-1:0]                  highest_seq_r, highest_seq_nxt;
  logic [CNT_W-1:0]               replies_missing_r, replies_missing_nxt;
  logic [MAX_NODES-1:0]           deferred_r, deferred_nxt;
  logic [MAX_NODES-1:0]           node_down_r, node_down_nxt;
  logic [CNT_W-1:0]               active_count_r, active_count_nxt;
  logic [CNT_W-1:0]               acks_missing_r, acks_missing_nxt;
  logic                           requesting_r, requesting_nxt;
  logic                           exited_r, exited_nxt;
  logic [CNT_W-1:0]               scan_idx_r, scan_idx_nxt;
  logic                           scan_rel_r, scan_rel_nxt;
  logic                           pend_valid_r, pend_valid_nxt;
  logic                           out_valid_r, out_valid_nxt;

  // payload
  dmn_pkg::cmd_t                  cmd_r, cmd_nxt;
  logic [IW-1:0]                  src_r, src_nxt;
  logic [SW-1:0]                  seq_r, seq_nxt;
  dmn_pkg::kind_t                 scan_kind_r, scan_kind_nxt;
  logic [SW-1:0]                  scan_seq_r, scan_seq_nxt;
  dmn_pkg::kind_t                 pend_kind_r, pend_kind_nxt;
  logic [IW-1:0]                  pend_dest_r, pend_dest_nxt;
  logic [SW-1:0]                  pend_seq_r, pend_seq_nxt;
  dmn_pkg::kind_t                 out_kind_r, out_kind_nxt;
  logic [IW-1:0]                  out_dest_r, out_dest_nxt;
  logic [SW-1:0]                  out_seq_r, out_seq_nxt;
  logic                           out_last_r, out_last_nxt;

  logic [CNT_W-1:0] n_eff;
  logic [IDX_W-1:0] src_sel;
  logic [IDX_W-1:0] scan_sel;
  logic             slot_free;
  logic             peer_cmd;
  logic             bad_src;
  logic             scan_hit;
  logic             scan_end;

  assign n_eff     = eff_count(node_count_r);
  assign src_sel   = IDX_W'(src_r);
  assign scan_sel  = scan_idx_r[IDX_W-1:0];
  assign slot_free = !out_valid_r || out_ready;
  assign peer_cmd  = (cmd_r == dmn_pkg::CMD_PEER_REQ) || (cmd_r == dmn_pkg::CMD_PEER_REPLY) ||
                     (cmd_r == dmn_pkg::CMD_PEER_SHUT) || (cmd_r == dmn_pkg::CMD_SHUT_ACK);
  assign bad_src   = (NW'(src_r) >= NW'(n_eff)) || (src_r == own_index_r);
  assign scan_end  = (scan_idx_r == n_eff);
  assign scan_hit  = scan_rel_r ? (deferred_r[scan_sel] && !node_down_r[scan_sel])
                                : ((NW'(scan_idx_r) != NW'(own_index_r)) &&
                                   !node_down_r[scan_sel]);

  always_comb begin
    state_nxt           = state_r;
    node_count_nxt      = node_count_r;
    own_index_nxt       = own_index_r;
    own_seq_nxt         = own_seq_r;
    highest_seq_nxt     = highest_seq_r;
    replies_missing_nxt = replies_missing_r;
    deferred_nxt        = deferred_r;
    node_down_nxt       = node_down_r;
    active_count_nxt    = active_count_r;
    acks_missing_nxt    = acks_missing_r;
    requesting_nxt      = requesting_r;
    exited_nxt          = exited_r;
    scan_idx_nxt        = scan_idx_r;
    scan_rel_nxt        = scan_rel_r;
    pend_valid_nxt      = pend_valid_r;
    cmd_nxt             = cmd_r;
    src_nxt             = src_r;
    seq_nxt             = seq_r;
    scan_kind_nxt       = scan_kind_r;
    scan_seq_nxt        = scan_seq_r;
    pend_kind_nxt       = pend_kind_r;
    pend_dest_nxt       = pend_dest_r;
    pend_seq_nxt        = pend_seq_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    out_kind_nxt        = out_kind_r;
    out_dest_nxt        = out_dest_r;
    out_seq_nxt         = out_seq_r;
    out_last_nxt        = out_last_r;
    in_ready            = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt   = dmn_pkg::cmd_t'(in_cmd);
          src_nxt   = in_source_index;
          seq_nxt   = in_seq_number;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_nxt = ST_IDLE;
        if (!exited_r && !(peer_cmd && bad_src)) begin
          case (cmd_r)
            dmn_pkg::CMD_CLIENT_REQ: begin
              if (!requesting_r) begin
                requesting_nxt      = 1'b1;
                own_seq_nxt         = (&highest_seq_r) ? highest_seq_r
                                                       : highest_seq_r + SW'(1);
                replies_missing_nxt = minus_one_floor(active_count_r);
                if (active_count_r <= CNT_W'(1)) begin
                  pend_kind_nxt  = dmn_pkg::KIND_GRANT;
                  pend_dest_nxt  = '0;
                  pend_seq_nxt   = '0;
                  pend_valid_nxt = 1'b1;
                  state_nxt      = ST_FLUSH;
                end else begin
                  scan_rel_nxt  = 1'b0;
                  scan_kind_nxt = dmn_pkg::KIND_REQ_PEER;
                  scan_seq_nxt  = own_seq_nxt;
                  scan_idx_nxt  = '0;
                  state_nxt     = ST_SCAN;
                end
              end
            end
            dmn_pkg::CMD_CLIENT_REL: begin
              requesting_nxt      = 1'b0;
              replies_missing_nxt = '0;
              scan_rel_nxt        = 1'b1;
              scan_kind_nxt       = dmn_pkg::KIND_REPLY_PEER;
              scan_seq_nxt        = '0;
              scan_idx_nxt        = '0;
              state_nxt           = ST_SCAN;
            end
            dmn_pkg::CMD_CLIENT_DONE: begin
              if (!requesting_r && acks_missing_r == '0) begin
                acks_missing_nxt = minus_one_floor(active_count_r);
                if (active_count_r <= CNT_W'(1)) begin
                  exited_nxt     = 1'b1;
                  pend_kind_nxt  = dmn_pkg::KIND_EXIT;
                  pend_dest_nxt  = '0;
                  pend_seq_nxt   = '0;
                  pend_valid_nxt = 1'b1;
                  state_nxt      = ST_FLUSH;
                end else begin
                  scan_rel_nxt  = 1'b0;
                  scan_kind_nxt = dmn_pkg::KIND_SHUT_NOTICE;
                  scan_seq_nxt  = '0;
                  scan_idx_nxt  = '0;
                  state_nxt     = ST_SCAN;
                end
              end
            end
            dmn_pkg::CMD_PEER_REQ: begin
              if (seq_r > highest_seq_r)
                highest_seq_nxt = seq_r;
              // lower index wins a tie
              if (requesting_r &&
                  (seq_r > own_seq_r || (seq_r == own_seq_r && own_index_r < src_r))) begin
                deferred_nxt[src_sel] = 1'b1;
              end else begin
                pend_kind_nxt  = dmn_pkg::KIND_REPLY_PEER;
                pend_dest_nxt  = src_r;
                pend_seq_nxt   = '0;
                pend_valid_nxt = 1'b1;
                state_nxt      = ST_FLUSH;
              end
            end
            dmn_pkg::CMD_PEER_REPLY: begin
              if (requesting_r && replies_missing_r != '0) begin
                replies_missing_nxt = replies_missing_r - CNT_W'(1);
                if (replies_missing_r == CNT_W'(1)) begin
                  pend_kind_nxt  = dmn_pkg::KIND_GRANT;
                  pend_dest_nxt  = '0;
                  pend_seq_nxt   = '0;
                  pend_valid_nxt = 1'b1;
                  state_nxt      = ST_FLUSH;
                end
              end
            end
            dmn_pkg::CMD_PEER_SHUT: begin
              if (!node_down_r[src_sel]) begin
                node_down_nxt[src_sel] = 1'b1;
                if (active_count_r != '0)
                  active_count_nxt = active_count_r - CNT_W'(1);
              end
              pend_kind_nxt  = dmn_pkg::KIND_SHUT_ACK;
              pend_dest_nxt  = src_r;
              pend_seq_nxt   = '0;
              pend_valid_nxt = 1'b1;
              state_nxt      = ST_FLUSH;
            end
            dmn_pkg::CMD_SHUT_ACK: begin
              if (acks_missing_r != '0) begin
                acks_missing_nxt = acks_missing_r - CNT_W'(1);
                if (acks_missing_r == CNT_W'(1)) begin
                  exited_nxt     = 1'b1;
                  pend_kind_nxt  = dmn_pkg::KIND_EXIT;
                  pend_dest_nxt  = '0;
                  pend_seq_nxt   = '0;
                  pend_valid_nxt = 1'b1;
                  state_nxt      = ST_FLUSH;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = pend_valid_r ? ST_FLUSH : ST_IDLE;
        end else if (!(scan_hit && pend_valid_r && !slot_free)) begin
          if (scan_rel_r)
            deferred_nxt[scan_sel] = 1'b0;
          if (scan_hit) begin
            // previous hit is known not to be the final one
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = pend_kind_r;
              out_dest_nxt  = pend_dest_r;
              out_seq_nxt   = pend_seq_r;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_kind_nxt  = scan_kind_r;
            pend_dest_nxt  = IW'(scan_idx_r);
            pend_seq_nxt   = scan_seq_r;
          end
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
        end
      end

      ST_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = pend_kind_r;
          out_dest_nxt   = pend_dest_r;
          out_seq_nxt    = pend_seq_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (cfg_we) begin
      unique case (dmn_pkg::cfg_idx_t'(cfg_index))
        dmn_pkg::CFG_NODE_COUNT: begin
          node_count_nxt   = cfg_wdata[dmn_pkg::NODE_CNT_W-1:0];
          active_count_nxt = eff_count(cfg_wdata[dmn_pkg::NODE_CNT_W-1:0]);
        end
        dmn_pkg::CFG_OWN_INDEX: own_index_nxt = cfg_wdata[IW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      node_count_r      <= dmn_pkg::NODE_COUNT_RST;
      own_index_r       <= '0;
      own_seq_r         <= '0;
      highest_seq_r     <= '0;
      replies_missing_r <= '0;
      deferred_r        <= '0;
      node_down_r       <= '0;
      active_count_r    <= eff_count(dmn_pkg::NODE_COUNT_RST);
      acks_missing_r    <= '0;
      requesting_r      <= 1'b0;
      exited_r          <= 1'b0;
      scan_idx_r        <= '0;
      scan_rel_r        <= 1'b0;
      pend_valid_r      <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      state_r           <= state_nxt;
      node_count_r      <= node_count_nxt;
      own_index_r       <= own_index_nxt;
      own_seq_r         <= own_seq_nxt;
      highest_seq_r     <= highest_seq_nxt;
      replies_missing_r <= replies_missing_nxt;
      deferred_r        <= deferred_nxt;
      node_down_r       <= node_down_nxt;
      active_count_r    <= active_count_nxt;
      acks_missing_r    <= acks_missing_nxt;
      requesting_r      <= requesting_nxt;
      exited_r          <= exited_nxt;
      scan_idx_r        <= scan_idx_nxt;
      scan_rel_r        <= scan_rel_nxt;
      pend_valid_r      <= pend_valid_nxt;
      out_valid_r       <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    src_r       <= src_nxt;
    seq_r       <= seq_nxt;
    scan_kind_r <= scan_kind_nxt;
    scan_seq_r  <= scan_seq_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_dest_r <= pend_dest_nxt;
    pend_seq_r  <= pend_seq_nxt;
    out_kind_r  <= out_kind_nxt;
    out_dest_r  <= out_dest_nxt;
    out_seq_r   <= out_seq_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_dest_index = out_dest_r;
  assign out_seq_out    = out_seq_r;
  assign out_last       = out_last_r;

endmodule

/* rtl/dmn_checker.sv */
// Port-level checks for the distributed mutex node, bound to the top level.
module dmn_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [2:0]                     out_kind,
  input logic [dmn_pkg::NODE_IDX_W-1:0] out_dest_index,
  input logic [dmn_pkg::SEQ_W-1:0]      out_seq_out,
  input logic                           out_last
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
    $stable(out_dest_index) && $stable(out_seq_out) && $stable(out_last))
    else $error("output changed while stalled");

  // each item is decoded before the next is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted back-to-back items");

  a_grant_exit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == dmn_pkg::KIND_GRANT || out_kind == dmn_pkg::KIND_EXIT)
    |-> out_dest_index == '0 && out_seq_out == '0 && out_last)
    else $error("grant or exit with nonzero address or not last");

  a_seq_only_on_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != dmn_pkg::KIND_REQ_PEER |-> out_seq_out == '0)
    else $error("sequence number on a non-request result");

endmodule

bind distributed_mutex_node dmn_checker u_dmn_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_kind       (out_kind),
  .out_dest_index (out_dest_index),
  .out_seq_out    (out_seq_out),
  .out_last       (out_last)
);

/* tb/sv/distributed_mutex_node_monitor.sv */
// Mutex node monitor: tracks node state from the channels and checks every result item.
module distributed_mutex_node_monitor
  import dmn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [2:0]            in_cmd,
  input  logic [NODE_IDX_W-1:0] in_source_index,
  input  logic [SEQ_W-1:0]      in_seq_number,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [2:0]            out_kind,
  input  logic [NODE_IDX_W-1:0] out_dest_index,
  input  logic [SEQ_W-1:0]      out_seq_out,
  input  logic                  out_last,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    awaited_count
);

  typedef struct packed {
    kind_t                 kind;
    logic [NODE_IDX_W-1:0] dest;
    logic [SEQ_W-1:0]      seq;
    logic                  last;
  } node_msg_t;

  node_msg_t awaited_msgs[$];
  node_msg_t head;

  logic [NODE_CNT_W-1:0] node_count_reg;
  logic [NODE_IDX_W-1:0] own_idx;
  logic [SEQ_W-1:0]      seq_mine, seq_top;
  logic [4:0]            replies_due, acks_due, live_nodes;
  logic [15:0]           deferred_set, down_set;
  logic                  wants_cs, has_exited;

  initial begin
    mismatch_count = 0;
    awaited_count  = 0;
  end

  task automatic report(input string what);
    $display("[%0t] node mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // node_count clamped to 1..16
  function automatic logic [4:0] live_limit();
    if (node_count_reg == 0) return 5'd1;
    if (node_count_reg > 16) return 5'd16;
    return node_count_reg;
  endfunction

  function automatic void queue_result(input kind_t k, input logic [3:0] d,
                                       input logic [31:0] s);
    node_msg_t m;
    m.kind = k;
    m.dest = d;
    m.seq  = s;
    m.last = 1'b0;
    awaited_msgs.push_back(m);
  endfunction

  // one item per live peer below n, rising index
  function automatic void announce(input kind_t k, input logic [31:0] s);
    logic [4:0] n;
    n = live_limit();
    for (int i = 0; i < int'(n); i++)
      if (i != int'(own_idx) && !down_set[i]) queue_result(k, 4'(i), s);
  endfunction

  task automatic node_response(input cmd_t c, input logic [3:0] src, input logic [31:0] sq);
    int unsigned first;
    logic [4:0] n;
    node_msg_t tail;
    n = live_limit();
    first = awaited_msgs.size();
    if (has_exited) return;
    if (c >= CMD_PEER_REQ && c <= CMD_SHUT_ACK && ({1'b0, src} >= n || src == own_idx))
      return;
    case (c)
      CMD_CLIENT_REQ: begin
        if (wants_cs) return;
        wants_cs = 1'b1;
        seq_mine = (seq_top == 32'hFFFF_FFFF) ? seq_top : seq_top + 1;
        replies_due = (live_nodes > 1) ? live_nodes - 1 : 5'd0;
        if (replies_due == 0) queue_result(KIND_GRANT, '0, '0);
        else announce(KIND_REQ_PEER, seq_mine);
      end
      CMD_CLIENT_REL: begin
        wants_cs = 1'b0;
        replies_due = '0;
        for (int i = 0; i < int'(n); i++) begin
          if (deferred_set[i]) begin
            deferred_set[i] = 1'b0;
            if (!down_set[i]) queue_result(KIND_REPLY_PEER, 4'(i), '0);
          end
        end
      end
      CMD_CLIENT_DONE: begin
        if (wants_cs || acks_due != 0) return;
        acks_due = (live_nodes > 1) ? live_nodes - 1 : 5'd0;
        if (acks_due == 0) begin
          has_exited = 1'b1;
          queue_result(KIND_EXIT, '0, '0);
        end else begin
          announce(KIND_SHUT_NOTICE, '0);
        end
      end
      CMD_PEER_REQ: begin
        if (sq > seq_top) seq_top = sq;
        // ties go to the lower node index
        if (wants_cs && (sq > seq_mine || (sq == seq_mine && own_idx < src)))
          deferred_set[src] = 1'b1;
        else
          queue_result(KIND_REPLY_PEER, src, '0);
      end
      CMD_PEER_REPLY: begin
        if (!wants_cs || replies_due == 0) return;
        replies_due--;
        if (replies_due == 0) queue_result(KIND_GRANT, '0, '0);
      end
      CMD_PEER_SHUT: begin
        if (!down_set[src]) begin
          down_set[src] = 1'b1;
          if (live_nodes > 0) live_nodes--;
        end
        queue_result(KIND_SHUT_ACK, src, '0);
      end
      CMD_SHUT_ACK: begin
        if (acks_due == 0) return;
        acks_due--;
        if (acks_due == 0) begin
          has_exited = 1'b1;
          queue_result(KIND_EXIT, '0, '0);
        end
      end
      default: ;
    endcase
    if (awaited_msgs.size() > first) begin
      tail = awaited_msgs.pop_back();
      tail.last = 1'b1;
      awaited_msgs.push_back(tail);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      node_count_reg = NODE_COUNT_RST;
      own_idx        = '0;
      seq_mine       = '0;
      seq_top        = '0;
      replies_due    = '0;
      acks_due       = '0;
      deferred_set   = '0;
      down_set       = '0;
      wants_cs       = 1'b0;
      has_exited     = 1'b0;
      live_nodes     = live_limit();
      awaited_msgs.delete();
      awaited_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_msgs.size() == 0) begin
          report($sformatf("unpredicted item kind %0d dest %0d", out_kind, out_dest_index));
        end else begin
          head = awaited_msgs.pop_front();
          if (out_kind !== head.kind)
            report($sformatf("kind %0d, predicted %0d", out_kind, head.kind));
          if (out_dest_index !== head.dest)
            report($sformatf("dest_index %0d, predicted %0d", out_dest_index, head.dest));
          if (out_seq_out !== head.seq)
            report($sformatf("seq_out %0h, predicted %0h", out_seq_out, head.seq));
          if (out_last !== head.last)
            report($sformatf("last %0b, predicted %0b", out_last, head.last));
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_NODE_COUNT: begin
            node_count_reg = cfg_wdata;
            live_nodes     = live_limit();
          end
          CFG_OWN_INDEX: own_idx = cfg_wdata[NODE_IDX_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        node_response(cmd_t'(in_cmd), in_source_index, in_seq_number);
      awaited_count <= awaited_msgs.size();
    end
  end

endmodule

/* tb/sv/distributed_mutex_node_tb.sv */
// Testbench top for the mutex node: message stimulus, config phases and the verdict.
module distributed_mutex_node_tb;
  import dmn_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [2:0]            in_cmd = '0;
  logic [NODE_IDX_W-1:0] in_source_index = '0;
  logic [SEQ_W-1:0]      in_seq_number = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [2:0]            out_kind;
  logic [NODE_IDX_W-1:0] out_dest_index;
  logic [SEQ_W-1:0]      out_seq_out;
  logic                  out_last;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    mismatch_count;
  int                    awaited_count;

  int         burst_left = 0;
  int         run_left = 0;
  int         stall_left = 0;
  int         sent_items = 0;
  logic [4:0] live_n = 5'd16;
  logic [3:0] own_cfg = '0;

  distributed_mutex_node dut (.*);
  distributed_mutex_node_monitor mon (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: ready runs of random length, some long, broken by short stalls
  always @(posedge clk) begin
    if (run_left > 0) begin
      out_ready <= 1'b1;
      run_left <= run_left - 1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      run_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
  end

  task automatic send_msg(input cmd_t c, input logic [3:0] src, input logic [31:0] sq);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    in_valid        <= 1'b1;
    in_cmd          <= c;
    in_source_index <= src;
    in_seq_number   <= sq;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    sent_items++;
  endtask

  // items may cause no result, so give the scan time to finish after the last one
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_count != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_config(input logic [4:0] n_val, input logic [4:0] own_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NODE_COUNT;
    cfg_wdata <= n_val;
    @(posedge clk);
    cfg_index <= CFG_OWN_INDEX;
    cfg_wdata <= own_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    live_n  = (n_val == 0) ? 5'd1 : (n_val > 16) ? 5'd16 : n_val;
    own_cfg = own_val[3:0];
  endtask

  // mostly a legal peer index, now and then any index
  function automatic logic [3:0] peer_src();
    logic [3:0] s;
    if ($urandom_range(0, 19) == 0 || (live_n == 5'd1 && own_cfg == 4'd0))
      return 4'($urandom_range(0, 15));
    do s = 4'($urandom_range(0, int'(live_n) - 1)); while (s == own_cfg);
    return s;
  endfunction

  // small values keep ties and deferrals likely
  function automatic logic [31:0] rand_seq();
    case ($urandom_range(0, 39))
      0: return '0;
      1: return $urandom;
      default: return $urandom_range(0, 64);
    endcase
  endfunction

  // request, replies with peer requests and the odd peer shutdown mixed in, then usually a release
  task automatic run_session();
    int span;
    int pick;
    send_msg(CMD_CLIENT_REQ, 4'($urandom), $urandom);
    span = int'(live_n) - 1 + $urandom_range(0, 3);
    for (int i = 0; i < span; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) send_msg(CMD_PEER_REQ, peer_src(), rand_seq());
      else if (pick < 37) send_msg(CMD_PEER_SHUT, peer_src(), $urandom);
      send_msg(CMD_PEER_REPLY, peer_src(), $urandom);
    end
    if ($urandom_range(0, 4) != 0) send_msg(CMD_CLIENT_REL, 4'($urandom), $urandom);
  endtask

  // done and ack stay out of the noise so the node does not exit early
  task automatic send_noise();
    cmd_t pool[6] = '{CMD_CLIENT_REQ, CMD_CLIENT_REL, CMD_PEER_REQ,
                      CMD_PEER_REPLY, CMD_PEER_SHUT, CMD_UNUSED};
    send_msg(pool[$urandom_range(0, 5)], 4'($urandom),
             ($urandom_range(0, 1) == 0) ? rand_seq() : $urandom);
  endtask

  initial begin
    bit early_shutdown;
    int phase_start;
    int wait_cycles;
    logic [4:0] n_val;
    logic [4:0] own_val;

    early_shutdown = 1'($urandom_range(0, 1));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: 16 nodes, own index 0
    send_msg(CMD_CLIENT_REQ, 4'd0, 32'd0);
    send_msg(CMD_CLIENT_REQ, 4'd9, 32'd0);
    send_msg(CMD_PEER_REQ, 4'd15, 32'd40);
    send_msg(CMD_PEER_REQ, 4'd3, 32'd1);
    send_msg(CMD_PEER_REQ, 4'd5, 32'd0);
    send_msg(CMD_PEER_REPLY, 4'd0, 32'd0);
    send_msg(CMD_UNUSED, 4'd1, 32'hFFFF_FFFF);
    send_msg(CMD_CLIENT_DONE, 4'd0, 32'd0);
    send_msg(CMD_SHUT_ACK, 4'd1, 32'd0);
    send_msg(CMD_PEER_SHUT, 4'd15, 32'd0);
    send_msg(CMD_PEER_SHUT, 4'd15, 32'd0);
    send_msg(CMD_CLIENT_REL, 4'd0, 32'd0);
    send_msg(CMD_CLIENT_REL, 4'd0, 32'd0);
    send_msg(CMD_PEER_REPLY, 4'd2, 32'd0);
    settle();

    set_config(5'd4, 5'd2);
    send_msg(CMD_CLIENT_REQ, 4'd0, 32'd0);
    send_msg(CMD_PEER_REQ, 4'd1, 32'd41);
    send_msg(CMD_PEER_REQ, 4'd3, 32'd41);
    send_msg(CMD_PEER_REQ, 4'd9, 32'd0);
    send_msg(CMD_PEER_REPLY, 4'd0, 32'd0);
    send_msg(CMD_PEER_REPLY, 4'd1, 32'd0);
    send_msg(CMD_PEER_REPLY, 4'd3, 32'd0);
    send_msg(CMD_PEER_REPLY, 4'd3, 32'd0);
    send_msg(CMD_CLIENT_REL, 4'd0, 32'd0);
    settle();

    // node_count 0 clamps to a single node; own index written with the spare bit set
    set_config(5'd0, 5'b11111);
    send_msg(CMD_CLIENT_REQ, 4'd0, 32'd0);
    send_msg(CMD_PEER_REQ, 4'd0, 32'd0);
    send_msg(CMD_CLIENT_REL, 4'd0, 32'd0);
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin n_val = 5'd16; own_val = 5'($urandom_range(0, 31)); end
        1: begin n_val = 5'd31; own_val = 5'd15; end
        2: begin n_val = 5'd1;  own_val = 5'd0;  end
        3: begin n_val = 5'd2;  own_val = 5'd1;  end
        default: begin
          n_val   = 5'($urandom_range(0, 31));
          own_val = 5'($urandom_range(0, 31));
        end
      endcase
      set_config(n_val, own_val);
      if (p == 0 && early_shutdown) begin
        // shutdown started but left incomplete; the node keeps serving requests
        send_msg(CMD_CLIENT_DONE, 4'($urandom), $urandom);
        repeat ($urandom_range(1, 4)) send_msg(CMD_SHUT_ACK, peer_src(), $urandom);
        send_msg(CMD_CLIENT_DONE, 4'($urandom), $urandom);
      end
      phase_start = sent_items;
      while (sent_items - phase_start < 10) begin
        if ($urandom_range(0, 9) < 7) run_session();
        else send_noise();
      end
      settle();
    end

    // saturated sequence numbers, ties broken both ways
    set_config(5'd16, 5'd7);
    send_msg(CMD_PEER_REQ, 4'd3, 32'hFFFF_FFFF);
    send_msg(CMD_CLIENT_REQ, 4'd0, 32'd0);
    send_msg(CMD_PEER_REQ, 4'd3, 32'hFFFF_FFFF);
    send_msg(CMD_PEER_REQ, 4'd12, 32'hFFFF_FFFF);
    send_msg(CMD_CLIENT_REL, 4'd0, 32'd0);
    settle();

    if (early_shutdown) begin
      repeat (20) send_msg(CMD_SHUT_ACK, peer_src(), $urandom);
    end else begin
      set_config(5'd1, 5'd0);
      send_msg(CMD_CLIENT_DONE, 4'd0, 32'd0);
    end
    // after exit everything is dropped
    send_msg(CMD_CLIENT_REQ, 4'd0, 32'd0);
    send_msg(CMD_PEER_SHUT, 4'd1, 32'd0);

    in_valid <= 1'b0;
    wait_cycles = 0;
    do begin
      @(posedge clk);
      wait_cycles++;
    end while (awaited_count != 0 && wait_cycles < 5000);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
